@@ sv/prs_pkg.sv @@
// shared types and fixed field widths for the pair ranking block
package prs_pkg;

  // result field widths, fixed by the output format
  localparam int RANK_W    = 5;
  localparam int POS_OUT_W = 5;
  localparam int SUM_OUT_W = 17;
  localparam int OUT_W     = 32;

  // classification of one accepted pair, passed from front to back
  typedef struct packed {
    logic keep;  // pair fits in the store
    logic last;  // final pair of the event
    logic ovf;   // a pair of this event has been dropped so far
  } prs_flags_t;

  localparam int FLAGS_W = $bits(prs_flags_t);

endpackage

@@ sv/prs_front.sv @@
// input side: adds the legs, numbers the pairs and flags dropped ones
module prs_front #(
  parameter int MAX_PAIRS = 32,
  parameter int PT_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         xfer,
  input  logic [PT_BITS-1:0]           leg1_pt,
  input  logic [PT_BITS-1:0]           leg2_pt,
  input  logic                         last_pair,
  output logic [PT_BITS:0]             sum,
  output logic [$clog2(MAX_PAIRS)-1:0] pos,
  output prs_pkg::prs_flags_t          flags
);

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = AW + 1;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          keep;

  // classify the pair against the store capacity
  assign keep        = (count_r < CW'(MAX_PAIRS));
  assign sum         = {1'b0, leg1_pt} + {1'b0, leg2_pt};
  assign pos         = count_r[AW-1:0];
  assign flags.keep  = keep;
  assign flags.last  = last_pair;
  assign flags.ovf   = ovf_r | ~keep;

  // per-event pair count and overflow tracking
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (xfer) begin
      if (last_pair) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (keep) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ sv/prs_fifo.sv @@
// two-entry queue between the front and the back
module prs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         not_empty
);

  logic [W-1:0] slot_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = slot_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ sv/prs_back.sv @@
// back side: insertion into a sorted store, then ranked readout per event
module prs_back #(
  parameter int MAX_PAIRS = 32,
  parameter int PT_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic [PT_BITS:0]                q_sum,
  input  logic [$clog2(MAX_PAIRS)-1:0]    q_pos,
  input  prs_pkg::prs_flags_t             q_flags,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [prs_pkg::RANK_W-1:0]      out_rank,
  output logic [prs_pkg::POS_OUT_W-1:0]   out_pos,
  output logic [prs_pkg::SUM_OUT_W-1:0]   out_sum,
  output logic                            out_ovf,
  output logic                            out_last
);

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = AW + 1;
  localparam int SW = PT_BITS + 1;
  localparam int EW = SW + AW;
  localparam int RANK_W    = prs_pkg::RANK_W;
  localparam int POS_OUT_W = prs_pkg::POS_OUT_W;
  localparam int SUM_OUT_W = prs_pkg::SUM_OUT_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  // sorted store, highest sum at address 0
  logic [EW-1:0] store_mem [MAX_PAIRS];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [SW-1:0] cur_sum_r, cur_sum_nxt;
  logic [AW-1:0] cur_pos_r, cur_pos_nxt;
  logic          cur_last_r, cur_last_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]    out_rank_r, out_rank_nxt;
  logic [POS_OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic [SUM_OUT_W-1:0] out_sum_r, out_sum_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_last_r, out_last_nxt;

  logic [SW-1:0] rd_sum;
  logic [AW-1:0] rd_pos;
  logic          out_free;
  logic          shift_go;
  logic          emit_end;

  assign rd_sum   = rd_q[SW-1:0];
  assign rd_pos   = rd_q[SW +: AW];
  assign out_free = ~out_valid_r | out_ready;
  assign shift_go = (j_r != '0) && (rd_sum < cur_sum_r);
  assign emit_end = ({1'b0, i_r} == (n_r - CW'(1)));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    j_nxt        = j_r;
    i_nxt        = i_r;
    cur_sum_nxt  = cur_sum_r;
    cur_pos_nxt  = cur_pos_r;
    cur_last_nxt = cur_last_r;
    ovf_nxt      = ovf_r;
    q_pop        = 1'b0;
    rd_addr      = i_r;
    wr_en        = 1'b0;
    wr_addr      = j_r;
    wr_data      = {cur_pos_r, cur_sum_r};
    out_valid_nxt = out_valid_r & ~out_ready;
    out_rank_nxt = out_rank_r;
    out_pos_nxt  = out_pos_r;
    out_sum_nxt  = out_sum_r;
    out_ovf_nxt  = out_ovf_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        // prefetch the lowest stored entry for the insertion walk
        rd_addr = AW'(n_r - CW'(1));
        if (q_valid) begin
          q_pop        = 1'b1;
          cur_sum_nxt  = q_sum;
          cur_pos_nxt  = q_pos;
          cur_last_nxt = q_flags.last;
          ovf_nxt      = q_flags.ovf;
          if (q_flags.keep) begin
            j_nxt     = n_r[AW-1:0];
            state_nxt = ST_SHIFT;
          end else if (q_flags.last) begin
            i_nxt     = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_SHIFT: begin
        // move smaller sums down one slot until the new pair fits
        rd_addr = j_r - AW'(2);
        wr_en   = 1'b1;
        if (shift_go) begin
          wr_data = rd_q;
          j_nxt   = j_r - AW'(1);
        end else begin
          n_nxt = n_r + CW'(1);
          if (cur_last_r) begin
            i_nxt     = '0;
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        rd_addr   = i_r;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // hand one ranked entry to the output register
        rd_addr = i_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = RANK_W'(i_r);
          out_pos_nxt   = POS_OUT_W'(rd_pos);
          out_sum_nxt   = SUM_OUT_W'(rd_sum);
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = emit_end;
          if (emit_end) begin
            n_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    cur_sum_r  <= cur_sum_nxt;
    cur_pos_r  <= cur_pos_nxt;
    cur_last_r <= cur_last_nxt;
    ovf_r      <= ovf_nxt;
    out_rank_r <= out_rank_nxt;
    out_pos_r  <= out_pos_nxt;
    out_sum_r  <= out_sum_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  // store memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_q <= store_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;
  assign out_pos   = out_pos_r;
  assign out_sum   = out_sum_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

endmodule

@@ sv/pair_rank_by_sum_pt.sv @@
// top level of the pair ranking block: ranks an event's pairs by falling pt sum
//
// Input channel in_*: one candidate pair per transfer, legs in in_tdata, the
// event's final pair flagged by in_tlast. Output channel out_*: after the
// final pair, one transfer per stored pair, highest sum first (equal sums in
// arrival order), with rank, arrival position and sum in out_tdata, the event
// overflow flag in out_tuser and the event's final result flagged by out_tlast.
// Up to MAX_PAIRS pairs are stored per event; later pairs are dropped and mark
// overflow on every result of that event.
// A two-entry queue sits behind the input. A stored pair is popped in the
// idle state, then the shift state moves each stored pair with a smaller sum
// down one slot and writes the new pair (insertion walk over the one-write,
// one-read store); a dropped pair is only popped. Readout starts once the
// final pair is inserted or dropped; per result, a read state is followed by
// a wait state that loads the output register. Reset empties the queue, the
// store and the output register. When the receiver stalls, the current result
// is held and readout pauses; the input keeps accepting until the queue fills.
module pair_rank_by_sum_pt #(
  parameter int MAX_PAIRS = 32,
  parameter int PT_BITS   = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // leg1_pt, leg2_pt
  input  logic [((2*PT_BITS+7)/8)*8-1:0]           in_tdata,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // rank, pair_position, sum_pt
  output logic [prs_pkg::OUT_W-1:0]                out_tdata,
  // overflow
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int AW   = $clog2(MAX_PAIRS);
  localparam int SW   = PT_BITS + 1;
  localparam int QW   = prs_pkg::FLAGS_W + AW + SW;
  localparam int PADW = prs_pkg::OUT_W - prs_pkg::RANK_W - prs_pkg::POS_OUT_W
                        - prs_pkg::SUM_OUT_W;

  logic                         in_xfer;
  logic [SW-1:0]                f_sum;
  logic [AW-1:0]                f_pos;
  prs_pkg::prs_flags_t          f_flags;
  logic [QW-1:0]                q_in, q_out;
  logic                         q_full, q_valid, q_pop;
  logic [prs_pkg::RANK_W-1:0]    o_rank;
  logic [prs_pkg::POS_OUT_W-1:0] o_pos;
  logic [prs_pkg::SUM_OUT_W-1:0] o_sum;

  assign in_tready = ~q_full;
  assign in_xfer   = in_tvalid & ~q_full;

  // front: classify and number the pairs
  prs_front #(
    .MAX_PAIRS(MAX_PAIRS),
    .PT_BITS  (PT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .xfer     (in_xfer),
    .leg1_pt  (in_tdata[PT_BITS-1:0]),
    .leg2_pt  (in_tdata[2*PT_BITS-1:PT_BITS]),
    .last_pair(in_tlast),
    .sum      (f_sum),
    .pos      (f_pos),
    .flags    (f_flags)
  );

  assign q_in = {f_flags, f_pos, f_sum};

  // queue decoupling intake from sorting
  prs_fifo #(
    .W(QW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .not_empty(q_valid)
  );

  // back: sorted insertion and ranked readout
  prs_back #(
    .MAX_PAIRS(MAX_PAIRS),
    .PT_BITS  (PT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_sum    (q_out[SW-1:0]),
    .q_pos    (q_out[SW +: AW]),
    .q_flags  (prs_pkg::prs_flags_t'(q_out[QW-1 -: prs_pkg::FLAGS_W])),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_rank (o_rank),
    .out_pos  (o_pos),
    .out_sum  (o_sum),
    .out_ovf  (out_tuser),
    .out_last (out_tlast)
  );

  // result packing, first field in the low bits
  assign out_tdata = {{PADW{1'b0}}, o_sum, o_pos, o_rank};

endmodule
